// ----- sv/grid_point_distance_unit_core_defines.svh -----
// Assertion macros
`ifndef GRID_POINT_DISTANCE_UNIT_CORE_DEFINES_SVH
`define GRID_POINT_DISTANCE_UNIT_CORE_DEFINES_SVH
`define GPD_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define GPD_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- sv/gpdu_pkg.sv -----
`timescale 1ns / 1ps
package gpdu_pkg;
  localparam int STAND_HEIGHT = 16;
  localparam int ZDIV = (STAND_HEIGHT / 2 == 0) ? 1 : STAND_HEIGHT / 2;
  localparam logic [16:0] UNREACH_DIST = 17'd32767;
  localparam int SW = 34;
  localparam int RW = 17;
  localparam int NSTEP = 17;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef enum logic [1:0] {
    FORM_CHEB   = 2'd0,
    FORM_PLANAR = 2'd1,
    FORM_SPATIAL = 2'd2,
    FORM_RSVD   = 2'd3
  } formula_t;

  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  dz;
    logic        unreach;
  } item_t;

  typedef struct packed {
    logic [RW-1:0] k2;
    logic [SW-1:0] r2;
    logic [RW-1:0] k3;
    logic [SW-1:0] r3;
  } root_t;

  typedef struct packed {
    logic          valid;
    item_t         it;
    logic [SW-1:0] s2;
    logic [SW-1:0] s3;
    root_t         rt;
  } stage_t;
endpackage

// ----- sv/grid_point_distance_unit_core.sv -----
`timescale 1ns / 1ps
// Grid point distance unit.
// Pipeline: front register, queue, squares, sums, square root in 17 pipelined bit steps,
// output register.
// Throughput: one transaction per cycle; busy never rises as the back end never stalls.
// Reset (rst, synchronous): formula register to 0, pipeline and queue emptied.
`default_nettype none
`include "grid_point_distance_unit_core_defines.svh"
module grid_point_distance_unit_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic signed [15:0] a_x,
  input  wire logic signed [15:0] a_y,
  input  wire logic signed [7:0]  a_z,
  input  wire logic [7:0]        a_map,
  input  wire logic signed [15:0] b_x,
  input  wire logic signed [15:0] b_y,
  input  wire logic signed [7:0]  b_z,
  input  wire logic [7:0]        b_map,
  input  wire logic              b_valid,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_data,
  output logic                   strobe,
  output logic [16:0]            dist_plane,
  output logic [16:0]            dist_spatial,
  output logic [15:0]            dist_sight,
  output logic                   unreachable
);
  logic [1:0]      formula;
  logic            take, fv, q_ne, q_af;
  gpdu_pkg::item_t fi, qi;

  always_ff @(posedge clk) begin
    if (rst) formula <= 2'(gpdu_pkg::FORM_CHEB);
    else if (cfg_we) formula <= cfg_data;
  end

  assign busy = q_af;
  assign take = start && !busy;

  gpdu_front u_front (
    .clk, .rst, .take, .a_x, .a_y, .a_z, .a_map, .b_x, .b_y, .b_z, .b_map, .b_valid,
    .item_valid(fv), .item(fi)
  );

  gpdu_fifo u_fifo (
    .clk, .rst, .push(fv), .din(fi), .pop(q_ne), .not_empty(q_ne),
    .almost_full(q_af), .dout(qi)
  );

  gpdu_back u_back (
    .clk, .rst, .formula, .in_valid(q_ne), .in_item(qi), .done(strobe),
    .dist_plane, .dist_spatial, .dist_sight, .unreachable
  );

  `GPD_ASSERT_NEXT(a_take_front, take, fv, "accepted item not classified")
  `GPD_ASSERT_IMPL(a_no_busy, q_ne, !busy || fv, "queue backs up")
  `GPD_ASSERT_NEXT(a_cfg, cfg_we, formula == $past(cfg_data), "formula write lost")
endmodule
`default_nettype wire

// ----- sv/gpdu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpdu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic signed [15:0] a_x,
  input  wire logic signed [15:0] a_y,
  input  wire logic signed [7:0]  a_z,
  input  wire logic [7:0]        a_map,
  input  wire logic signed [15:0] b_x,
  input  wire logic signed [15:0] b_y,
  input  wire logic signed [7:0]  b_z,
  input  wire logic [7:0]        b_map,
  input  wire logic              b_valid,
  output logic                   item_valid,
  output gpdu_pkg::item_t        item
);
  logic signed [16:0] ddx, ddy;
  logic signed [8:0]  ddz;
  gpdu_pkg::item_t    item_next;

  always_comb begin
    ddx = 17'(a_x) - 17'(b_x);
    ddy = 17'(a_y) - 17'(b_y);
    ddz = 9'(a_z) - 9'(b_z);
    item_next.dx = ddx[16] ? 16'(-ddx) : ddx[15:0];
    item_next.dy = ddy[16] ? 16'(-ddy) : ddy[15:0];
    item_next.dz = ddz[8] ? 8'(-ddz) : ddz[7:0];
    item_next.unreach = !b_valid || (a_map != b_map);
  end

  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else item_valid <= take;
    item <= item_next;
  end
endmodule
`default_nettype wire

// ----- sv/gpdu_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpdu_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire gpdu_pkg::item_t din,
  input  wire logic            pop,
  output logic                 not_empty,
  output logic                 almost_full,
  output gpdu_pkg::item_t      dout
);
  gpdu_pkg::item_t mem [gpdu_pkg::QDEPTH];
  logic [gpdu_pkg::QAW-1:0] wp, rp;
  logic [gpdu_pkg::QAW:0]   cnt;

  assign not_empty = (cnt != '0);
  assign almost_full = (cnt >= (gpdu_pkg::QAW+1)'(gpdu_pkg::QDEPTH - 2));
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (gpdu_pkg::QAW+1)'(push) - (gpdu_pkg::QAW+1)'(pop);
    end
    if (push) mem[wp] <= din;
  end
endmodule
`default_nettype wire

// ----- sv/gpdu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "grid_point_distance_unit_core_defines.svh"
module gpdu_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [1:0]      formula,
  input  wire logic            in_valid,
  input  wire gpdu_pkg::item_t in_item,
  output logic                 done,
  output logic [16:0]          dist_plane,
  output logic [16:0]          dist_spatial,
  output logic [15:0]          dist_sight,
  output logic                 unreachable
);
  localparam int N = gpdu_pkg::NSTEP;
  localparam int SW = gpdu_pkg::SW;
  localparam int RW = gpdu_pkg::RW;

  // stage 0: squares, stage 1: sums, stages 2..N+1: one root bit each
  gpdu_pkg::item_t  sq_it;
  logic             sq_v;
  logic [31:0]      sqx, sqy;
  logic [15:0]      sqz;
  gpdu_pkg::stage_t st [N+1];

  // restoring square root, bit b decided per step
  function automatic gpdu_pkg::root_t root_step(logic [SW-1:0] s2, logic [SW-1:0] s3,
                                                gpdu_pkg::root_t r, int b);
    gpdu_pkg::root_t n;
    logic [SW-1:0] t2, t3;
    n = r;
    t2 = (SW'(r.k2) << (b + 1)) + (SW'(1) << (2 * b));
    t3 = (SW'(r.k3) << (b + 1)) + (SW'(1) << (2 * b));
    if (s2 >= r.r2 + t2) begin
      n.r2 = r.r2 + t2;
      n.k2 = r.k2 | (RW'(1) << b);
    end
    if (s3 >= r.r3 + t3) begin
      n.r3 = r.r3 + t3;
      n.k3 = r.k3 | (RW'(1) << b);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) sq_v <= 1'b0;
    else sq_v <= in_valid;
    sq_it <= in_item;
    sqx <= in_item.dx * in_item.dx;
    sqy <= in_item.dy * in_item.dy;
    sqz <= in_item.dz * in_item.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) st[0].valid <= 1'b0;
    else st[0].valid <= sq_v;
    st[0].it <= sq_it;
    st[0].s2 <= SW'(sqx) + SW'(sqy);
    st[0].s3 <= SW'(sqx) + SW'(sqy) + SW'(sqz);
    st[0].rt <= '0;
    for (int j = 0; j < N; j++) begin
      if (rst) st[j+1].valid <= 1'b0;
      else st[j+1].valid <= st[j].valid;
      st[j+1].it <= st[j].it;
      st[j+1].s2 <= st[j].s2;
      st[j+1].s3 <= st[j].s3;
      st[j+1].rt <= root_step(st[j].s2, st[j].s3, st[j].rt, N - 1 - j);
    end
  end

  // rounding: s - k*k > k  <=>  s >= k*k+k+1
  gpdu_pkg::stage_t f;
  logic [RW-1:0] e2, e3, base, plane, zs, cheb;
  assign f = st[N];
  always_comb begin
    e2 = f.rt.k2 + RW'((f.s2 - f.rt.r2) > SW'(f.rt.k2));
    e3 = f.rt.k3 + RW'((f.s3 - f.rt.r3) > SW'(f.rt.k3));
    cheb = (f.it.dx >= f.it.dy) ? RW'(f.it.dx) : RW'(f.it.dy);
    zs = RW'(f.it.dz / 8'(gpdu_pkg::ZDIV));
    base = (formula == gpdu_pkg::FORM_PLANAR) ? e2 : cheb;
    if (formula == gpdu_pkg::FORM_SPATIAL) begin
      plane = f.it.unreach ? gpdu_pkg::UNREACH_DIST : e3;
    end else begin
      plane = f.it.unreach ? gpdu_pkg::UNREACH_DIST : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= f.valid;
    dist_plane <= plane;
    if (formula == gpdu_pkg::FORM_SPATIAL) dist_spatial <= e3;
    else dist_spatial <= (zs >= plane) ? zs : plane;
    dist_sight <= f.it.unreach ? 16'd32767 : cheb[15:0];
    unreachable <= f.it.unreach;
  end

  `GPD_ASSERT_NEXT(a_done_follows, f.valid, done, "result strobe lost")
  `GPD_ASSERT_NEXT(a_unreach_sight, f.valid && f.it.unreach,
    dist_sight == 16'd32767, "sentinel missing")
  `GPD_ASSERT_IMPL(a_root_bound, f.valid, f.rt.r3 <= f.s3, "root overshoot")
endmodule
`default_nettype wire

// ----- test/grid_point_distance_unit_core_tb.sv -----
`timescale 1ns / 1ps
module grid_point_distance_unit_core_tb;

  typedef struct {
    logic signed [15:0] ax, ay, bx, by;
    logic signed [7:0]  az, bz;
    logic [7:0]         amap, bmap;
    logic               bvalid;
  } pair_t;

  typedef struct {
    logic [16:0] plane, spatial;
    logic [15:0] sight;
    logic        unr;
  } dist_t;

  typedef struct {
    pair_t p;
    bit    known;
    dist_t d;
  } row_t;

  localparam int DRAIN = 40;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [15:0] a_x = 0, a_y = 0, b_x = 0, b_y = 0;
  logic signed [7:0] a_z = 0, b_z = 0;
  logic [7:0] a_map = 0, b_map = 0;
  logic b_valid = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_data = 0;
  logic strobe;
  logic [16:0] dist_plane, dist_spatial;
  logic [15:0] dist_sight;
  logic unreachable;

  gpdu_pkg::formula_t formula = gpdu_pkg::FORM_CHEB;
  dist_t pending_dists[$];
  int errors = 0;
  int sender_idle = 0;

  grid_point_distance_unit_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_map(a_map),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_map(b_map), .b_valid(b_valid),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .strobe(strobe), .dist_plane(dist_plane), .dist_spatial(dist_spatial),
    .dist_sight(dist_sight), .unreachable(unreachable)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] rounded_root(logic [63:0] s);
    logic [63:0] k;
    k = 0;
    for (int b = 31; b >= 0; b--)
      if ((k | (64'd1 << b)) * (k | (64'd1 << b)) <= s) k |= 64'd1 << b;
    if (s >= k * k + k + 1) k++;
    return k;
  endfunction

  function automatic dist_t grid_distances(pair_t p, gpdu_pkg::formula_t f);
    dist_t d;
    logic [31:0] dx, dy, dz, cheb, base, zs, e3;
    logic [63:0] s2;
    dx = (p.ax > p.bx) ? 32'(p.ax - p.bx) : 32'(p.bx - p.ax);
    dy = (p.ay > p.by) ? 32'(p.ay - p.by) : 32'(p.by - p.ay);
    dz = (p.az > p.bz) ? 32'(p.az - p.bz) : 32'(p.bz - p.az);
    d.unr = !p.bvalid || (p.amap != p.bmap);
    cheb = (dx >= dy) ? dx : dy;
    s2 = 64'(dx) * dx + 64'(dy) * dy;
    e3 = 32'(rounded_root(s2 + 64'(dz) * dz));
    if (f == gpdu_pkg::FORM_SPATIAL) begin
      d.plane = d.unr ? gpdu_pkg::UNREACH_DIST : 17'(e3);
      d.spatial = 17'(e3);
    end else begin
      base = (f == gpdu_pkg::FORM_PLANAR) ? 32'(rounded_root(s2)) : cheb;
      zs = dz / gpdu_pkg::ZDIV;
      base = d.unr ? 32'(gpdu_pkg::UNREACH_DIST) : base;
      d.plane = 17'(base);
      d.spatial = 17'((zs >= base) ? zs : base);
    end
    d.sight = d.unr ? 16'(gpdu_pkg::UNREACH_DIST) : 16'(cheb);
    return d;
  endfunction

  always @(posedge clk) begin
    dist_t e;
    if (!rst && strobe) begin
      if (pending_dists.size() == 0) begin
        $display("%0t: unexpected result plane=%0d spatial=%0d sight=%0d unr=%0b",
                 $time, dist_plane, dist_spatial, dist_sight, unreachable);
        errors++;
      end else begin
        e = pending_dists.pop_front();
        if (dist_plane !== e.plane) begin
          $display("%0t: dist_plane expected %0d actual %0d", $time, e.plane, dist_plane);
          errors++;
        end
        if (dist_spatial !== e.spatial) begin
          $display("%0t: dist_spatial expected %0d actual %0d", $time, e.spatial,
                   dist_spatial);
          errors++;
        end
        if (dist_sight !== e.sight) begin
          $display("%0t: dist_sight expected %0d actual %0d", $time, e.sight, dist_sight);
          errors++;
        end
        if (unreachable !== e.unr) begin
          $display("%0t: unreachable expected %0b actual %0b", $time, e.unr, unreachable);
          errors++;
        end
      end
    end
  end

  task automatic set_formula(gpdu_pkg::formula_t f);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= f;
    @(posedge clk);
    cfg_we <= 0;
    formula = f;
  endtask

  task automatic wait_idle();
    start <= 0;
    while (pending_dists.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // one transaction, called at a clock edge; expectation pushed at the accepting edge
  task automatic send_pair(pair_t p, bit known, dist_t d);
    while ($urandom_range(99) < sender_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    a_x <= p.ax; a_y <= p.ay; a_z <= p.az; a_map <= p.amap;
    b_x <= p.bx; b_y <= p.by; b_z <= p.bz; b_map <= p.bmap; b_valid <= p.bvalid;
    do @(posedge clk); while (busy);
    pending_dists.push_back(known ? d : grid_distances(p, formula));
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int m;
    m = $urandom_range(9);
    p.ax = 16'($urandom); p.ay = 16'($urandom); p.bx = 16'($urandom); p.by = 16'($urandom);
    p.az = 8'($urandom); p.bz = 8'($urandom);
    if (m < 4) begin
      p.bx = p.ax + 16'($signed(8'($urandom)));
      p.by = p.ay + 16'($signed(8'($urandom)));
    end
    p.amap = 8'($urandom);
    p.bmap = (m < 8) ? p.amap : 8'($urandom);
    p.bvalid = ($urandom_range(9) != 0);
    return p;
  endfunction

  function automatic row_t mk(int ax, int ay, int az, int am, int bx, int by, int bz,
                              int bm, bit bv, bit known, int pl, int sp, int si,
                              bit un);
    row_t r;
    r.p = '{ax: ax, ay: ay, az: az, amap: am, bx: bx, by: by, bz: bz, bmap: bm,
            bvalid: bv};
    r.known = known;
    r.d = '{plane: pl, spatial: sp, sight: si, unr: un};
    return r;
  endfunction

  initial begin
    row_t rows[$];
    gpdu_pkg::formula_t forms[4];
    dist_t none;
    forms = '{gpdu_pkg::FORM_PLANAR, gpdu_pkg::FORM_SPATIAL, gpdu_pkg::FORM_RSVD,
              gpdu_pkg::FORM_CHEB};
    none = '{plane: 0, spatial: 0, sight: 0, unr: 0};
    repeat (10) @(posedge clk);
    rst <= 0;

    // formula 0 after reset
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    rows.push_back(mk(-32768, 0, 0, 3, 32767, 5, 0, 3, 1, 1, 65535, 65535, 65535, 0));
    rows.push_back(mk(0, -32768, -128, 7, 1, 32767, 127, 7, 1, 1, 65535, 65535, 65535, 0));
    rows.push_back(mk(0, 0, -128, 1, 0, 0, 127, 1, 1, 1, 0, 31, 0, 0));
    rows.push_back(mk(0, 0, 0, 1, 3, 4, 0, 1, 0, 1, 32767, 32767, 32767, 1));
    rows.push_back(mk(0, 0, 0, 255, 3, 4, 0, 0, 1, 1, 32767, 32767, 32767, 1));
    rows.push_back(mk(10, 20, 5, 9, 13, 24, 20, 9, 1, 0, 0, 0, 0, 0));
    foreach (rows[i]) send_pair(rows[i].p, rows[i].known, rows[i].d);
    wait_idle();

    foreach (forms[f]) begin
      set_formula(forms[f]);
      foreach (rows[i]) send_pair(rows[i].p, 0, none);
      send_pair(mk(-32768, -32768, -128, 0, 32767, 32767, 127, 0, 1, 0, 0, 0, 0, 0).p,
                0, none);
      send_pair(mk(-32768, -32768, -128, 0, 32767, 32767, 127, 1, 1, 0, 0, 0, 0, 0).p,
                0, none);
      wait_idle();
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_formula(gpdu_pkg::formula_t'(ph % 4));
      sender_idle = (ph % 4 == 1) ? 76 : (ph % 4 == 3) ? 20 : 0;
      repeat (190) send_pair(random_pair(), 0, none);
      wait_idle();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/gpdu_pkg.sv
sv/gpdu_front.sv
sv/gpdu_fifo.sv
sv/gpdu_back.sv
sv/grid_point_distance_unit_core.sv
test/grid_point_distance_unit_core_tb.sv
